// ===== rtl/core/tpp_pkg.sv =====
package tpp_pkg;

   typedef enum logic [1:0] {
      CMD_L2W_POINT  = 2'd0,
      CMD_L2W_VECTOR = 2'd1,
      CMD_W2L_POINT  = 2'd2,
      CMD_W2L_VECTOR = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_OFFSET_X    = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
   localparam logic [2:0] REG_OFFSET_Z    = 3'd2;
   localparam logic [2:0] REG_ROTATION_XY = 3'd3;
   localparam logic [2:0] REG_ROTATION_ZW = 3'd4;
   localparam logic [2:0] REG_SCALE_X     = 3'd5;
   localparam logic [2:0] REG_SCALE_Y     = 3'd6;
   localparam logic [2:0] REG_SCALE_Z     = 3'd7;

   localparam logic [31:0] RESET_ROTATION_ZW = 32'h0000_4000;
   localparam logic [31:0] RESET_SCALE       = 32'h0001_0000;

   typedef struct packed {
      logic             busy;
      logic [2:0]       of;
      logic [2:0][31:0] value;
   } recip_stat_type;

   // Clamps a wide signed value to 32 bits; the top bit of the result flags saturation.
   function automatic logic [32:0] sat32(input logic signed [69:0] v);
      logic [32:0] r;
      if (v > 70'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -70'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/tpp_recip.sv =====
module tpp_recip
   import tpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][31:0]      scale,
   output recip_stat_type        stat
);

   logic [5:0]  cnt_ff;
   logic [31:0] mag_ff [3];
   logic [31:0] rem_ff [3];
   logic [33:0] num_ff [3];
   logic [33:0] quo_ff [3];
   logic        neg_ff [3];
   logic        zero_ff [3];

   logic [32:0] trial [3];
   logic [32:0] rem_in [3];
   logic        bit_in [3];
   logic [31:0] mag_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         mag_in[a] = scale[a][31] ? (32'd0 - scale[a]) : scale[a];
         trial[a]  = {rem_ff[a], num_ff[a][33]};
         bit_in[a] = trial[a] >= {1'b0, mag_ff[a]};
         rem_in[a] = bit_in[a] ? (trial[a] - {1'b0, mag_ff[a]}) : trial[a];
      end
   end

   // One quotient bit per cycle and axis, all three axes side by side.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         for (int a = 0; a < 3; a++) begin
            quo_ff[a]  <= 34'd65536;
            neg_ff[a]  <= 1'b0;
            zero_ff[a] <= 1'b0;
         end
      end else if (start) begin
         cnt_ff <= 6'd34;
         for (int a = 0; a < 3; a++) begin
            mag_ff[a]  <= mag_in[a];
            rem_ff[a]  <= 32'd0;
            num_ff[a]  <= 34'h1_0000_0000 + {3'd0, mag_in[a][31:1]};
            quo_ff[a]  <= 34'd0;
            neg_ff[a]  <= scale[a][31];
            zero_ff[a] <= scale[a] == 32'd0;
         end
      end else if (cnt_ff != 6'd0) begin
         cnt_ff <= cnt_ff - 6'd1;
         for (int a = 0; a < 3; a++) begin
            rem_ff[a] <= rem_in[a][31:0];
            num_ff[a] <= {num_ff[a][32:0], 1'b0};
            quo_ff[a] <= {quo_ff[a][32:0], bit_in[a]};
         end
      end
   end

   always_comb begin
      stat.busy = cnt_ff != 6'd0;
      for (int a = 0; a < 3; a++) begin
         if (zero_ff[a]) begin
            stat.of[a]    = 1'b0;
            stat.value[a] = 32'd0;
         end else if (!neg_ff[a]) begin
            stat.of[a]    = quo_ff[a] > 34'h0_7FFF_FFFF;
            stat.value[a] = stat.of[a] ? 32'h7FFF_FFFF : quo_ff[a][31:0];
         end else begin
            stat.of[a]    = quo_ff[a] > 34'h0_8000_0000;
            stat.value[a] = stat.of[a] ? 32'h8000_0000 : (32'd0 - quo_ff[a][31:0]);
         end
      end
   end

endmodule

// ===== rtl/core/transform_point_by_pose.sv =====
// A transaction accepted at req_ passes through the stage registers and shows its result at rsp_.
// Throughput: one transaction per cycle through a seven-stage pipeline of multipliers and adders
// when rsp_tready is high and the reciprocal unit is idle. After a write to a scale register the
// reciprocal unit works one bit a cycle; req_tready stays low from its start strobe until done.
// Reset (synchronous, active high) empties the pipeline and loads the identity pose.
module transform_point_by_pose
   import tpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // in_x, in_y, in_z
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_z
   output logic        rsp_tuser,   // overflow
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [31:0] off_ff [3];
   logic [31:0] scl_ff [3];
   logic [31:0] rot_xy_ff;
   logic [31:0] rot_zw_ff;
   logic        start_ff;
   recip_stat_type rstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            off_ff[a] <= 32'd0;
            scl_ff[a] <= RESET_SCALE;
         end
         rot_xy_ff <= 32'd0;
         rot_zw_ff <= RESET_ROTATION_ZW;
         start_ff  <= 1'b0;
      end else begin
         start_ff <= csr_we && (csr_addr == REG_SCALE_X || csr_addr == REG_SCALE_Y ||
                                csr_addr == REG_SCALE_Z);
         if (csr_we) begin
            case (csr_addr)
               REG_OFFSET_X:    off_ff[0] <= csr_wdata;
               REG_OFFSET_Y:    off_ff[1] <= csr_wdata;
               REG_OFFSET_Z:    off_ff[2] <= csr_wdata;
               REG_ROTATION_XY: rot_xy_ff <= csr_wdata;
               REG_ROTATION_ZW: rot_zw_ff <= csr_wdata;
               REG_SCALE_X:     scl_ff[0] <= csr_wdata;
               REG_SCALE_Y:     scl_ff[1] <= csr_wdata;
               REG_SCALE_Z:     scl_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   tpp_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .scale ({scl_ff[2], scl_ff[1], scl_ff[0]}),
      .stat  (rstat)
   );

   // Rotation matrix with 28 fractional bits, refreshed every cycle from the registers.
   logic signed [15:0] qx, qy, qz, qw;
   logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [33:0] m_in [9];
   logic signed [33:0] m_ff [9];
   localparam logic signed [33:0] ONE = 34'sd268435456;

   always_comb begin
      qx = rot_xy_ff[31:16];
      qy = rot_xy_ff[15:0];
      qz = rot_zw_ff[31:16];
      qw = rot_zw_ff[15:0];
      xx = (34'(qx) * 34'(qx)) <<< 1;
      yy = (34'(qy) * 34'(qy)) <<< 1;
      zz = (34'(qz) * 34'(qz)) <<< 1;
      xy = (34'(qx) * 34'(qy)) <<< 1;
      xz = (34'(qx) * 34'(qz)) <<< 1;
      yz = (34'(qy) * 34'(qz)) <<< 1;
      wx = (34'(qw) * 34'(qx)) <<< 1;
      wy = (34'(qw) * 34'(qy)) <<< 1;
      wz = (34'(qw) * 34'(qz)) <<< 1;
      m_in[0] = ONE - yy - zz; m_in[1] = xy - wz;       m_in[2] = xz + wy;
      m_in[3] = xy + wz;       m_in[4] = ONE - xx - zz; m_in[5] = yz - wx;
      m_in[6] = xz - wy;       m_in[7] = yz + wx;       m_in[8] = ONE - xx - yy;
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < 9; e++) m_ff[e] <= m_in[e];
   end

   // Stage valids and enables; a stage moves when it is empty or the next one moves.
   logic [7:1] v_ff;
   logic [7:1] en;
   logic       accept;

   always_comb begin
      en[7] = !v_ff[7] || rsp_tready;
      for (int s = 6; s >= 1; s--) en[s] = !v_ff[s] || en[s + 1];
   end

   assign req_tready = en[1] && !rstat.busy && !start_ff;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= accept;
         for (int s = 2; s <= 7; s++) begin
            if (en[s]) v_ff[s] <= v_ff[s - 1];
         end
      end
   end

   // Payload registers per stage.
   cmd_type            cmd_ff [6:1];
   logic               of_ff [7:2];
   logic signed [63:0] p1_ff [3];
   logic signed [32:0] d1_ff [3];
   logic signed [31:0] v2_ff [3];
   logic signed [50:0] ph3_ff [9];
   logic signed [50:0] pl3_ff [9];
   logic signed [52:0] hi4_ff [3];
   logic signed [52:0] lo4_ff [3];
   logic signed [31:0] r5_ff [3];
   logic signed [32:0] a6_ff [3];
   logic signed [63:0] p6_ff [3];
   logic [31:0]        r7_ff [3];

   logic [32:0]        sat2 [3];
   logic               of2_in;
   logic signed [31:0] in_w [3];
   logic signed [15:0] vh [3];
   logic signed [16:0] vl [3];
   logic signed [33:0] mat [9];
   logic signed [69:0] tot [3];
   logic [32:0]        sat5 [3];
   logic               of5_in;
   logic [32:0]        sat7 [3];
   logic               of7_in;

   always_comb begin
      for (int a = 0; a < 3; a++) in_w[a] = req_tdata[32 * a +: 32];

      of2_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!cmd_ff[1][1]) begin
            sat2[a] = sat32((70'(p1_ff[a]) + 70'sd32768) >>> 16);
         end else begin
            sat2[a] = sat32(70'(d1_ff[a]));
         end
         of2_in = of2_in | sat2[a][32];
      end

      for (int a = 0; a < 3; a++) begin
         vh[a] = v2_ff[a][31:16];
         vl[a] = {1'b0, v2_ff[a][15:0]};
      end
      // The conjugate rotation is the transpose of the matrix.
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            mat[i * 3 + k] = cmd_ff[2][1] ? m_ff[k * 3 + i] : m_ff[i * 3 + k];
         end
      end

      of5_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         tot[i]  = (70'(hi4_ff[i]) <<< 16) + 70'(lo4_ff[i]) + (70'sd1 <<< 27);
         sat5[i] = sat32(tot[i] >>> 28);
         of5_in  = of5_in | sat5[i][32];
      end

      of7_in = of_ff[6];
      for (int a = 0; a < 3; a++) begin
         if (cmd_ff[6][1]) begin
            sat7[a] = sat32((70'(p6_ff[a]) + 70'sd32768) >>> 16);
         end else begin
            sat7[a] = sat32(70'(a6_ff[a]));
         end
         of7_in = of7_in | sat7[a][32];
      end
      if (cmd_ff[6][1]) of7_in = of7_in | (|rstat.of);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cmd_ff[1] <= cmd_type'(req_tuser);
         for (int a = 0; a < 3; a++) begin
            p1_ff[a] <= 64'(in_w[a]) * 64'($signed(scl_ff[a]));
            d1_ff[a] <= req_tuser[0] ? 33'(in_w[a])
                                     : 33'(in_w[a]) - 33'($signed(off_ff[a]));
         end
      end
      if (en[2]) begin
         cmd_ff[2] <= cmd_ff[1];
         of_ff[2]  <= of2_in;
         for (int a = 0; a < 3; a++) v2_ff[a] <= sat2[a][31:0];
      end
      if (en[3]) begin
         cmd_ff[3] <= cmd_ff[2];
         of_ff[3]  <= of_ff[2];
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               ph3_ff[i * 3 + k] <= 51'(vh[k]) * 51'(mat[i * 3 + k]);
               pl3_ff[i * 3 + k] <= 51'(vl[k]) * 51'(mat[i * 3 + k]);
            end
         end
      end
      if (en[4]) begin
         cmd_ff[4] <= cmd_ff[3];
         of_ff[4]  <= of_ff[3];
         for (int i = 0; i < 3; i++) begin
            hi4_ff[i] <= 53'(ph3_ff[i * 3]) + 53'(ph3_ff[i * 3 + 1]) + 53'(ph3_ff[i * 3 + 2]);
            lo4_ff[i] <= 53'(pl3_ff[i * 3]) + 53'(pl3_ff[i * 3 + 1]) + 53'(pl3_ff[i * 3 + 2]);
         end
      end
      if (en[5]) begin
         cmd_ff[5] <= cmd_ff[4];
         of_ff[5]  <= of_ff[4] | of5_in;
         for (int i = 0; i < 3; i++) r5_ff[i] <= sat5[i][31:0];
      end
      if (en[6]) begin
         cmd_ff[6] <= cmd_ff[5];
         of_ff[6]  <= of_ff[5];
         for (int a = 0; a < 3; a++) begin
            a6_ff[a] <= cmd_ff[5][0] ? 33'(r5_ff[a])
                                     : 33'(r5_ff[a]) + 33'($signed(off_ff[a]));
            p6_ff[a] <= 64'(r5_ff[a]) * 64'($signed(rstat.value[a]));
         end
      end
      if (en[7]) begin
         of_ff[7]  <= of7_in;
         for (int a = 0; a < 3; a++) r7_ff[a] <= sat7[a][31:0];
      end
   end

   assign rsp_tvalid = v_ff[7];
   assign rsp_tdata  = {r7_ff[2], r7_ff[1], r7_ff[0]};
   assign rsp_tuser  = of_ff[7];

endmodule

// ===== rtl/core/tpp_checker.sv =====
module tpp_checker
   import tpp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_we,
   input logic [2:0]  csr_addr
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown straight after reset");

   a_scale_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_addr == REG_SCALE_X || csr_addr == REG_SCALE_Y ||
                 csr_addr == REG_SCALE_Z) |=> !req_tready)
      else $error("input taken while the reciprocals are recomputed");

endmodule

bind transform_point_by_pose tpp_checker u_tpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr)
);
